### sv/tcfp_pkg.sv
// ----------------------------------------------------------------------------
// Tuning command frame parser package
// Shared constants and types for the frame parser and its value decoder.
// ----------------------------------------------------------------------------
package tcfp_pkg;

	localparam logic [7:0] HEADER_BYTE     = 8'hF0;
	localparam logic [7:0] SWITCH_ON_BYTE  = 8'h0A;
	localparam logic [7:0] SWITCH_OFF_BYTE = 8'hB0;

	localparam logic [7:0] MODE_PARAM  = 8'd0;
	localparam logic [7:0] MODE_SELECT = 8'd1;
	localparam logic [7:0] MODE_SWITCH = 8'd2;

	localparam logic [7:0] SELECT_SLOTS = 8'd9;
	localparam logic [2:0] FRAME_LAST   = 3'd4;

	localparam logic [7:0] EXP_BIAS       = 8'd127;
	localparam logic [7:0] EXP_ALL_ONES   = 8'hFF;
	localparam logic [7:0] SAT_EXP_LIMIT  = 8'd8;
	localparam logic [7:0] LOW_EXP_LIMIT  = 8'd31;
	localparam logic [4:0] SAT_SHIFT_BASE = 5'd23;
	localparam logic [4:0] LOW_SHIFT_BASE = 5'd30;

	localparam logic [7:0] VALUE_MAX = 8'hFF;
	localparam logic [7:0] VALUE_ONE = 8'd1;

	typedef enum logic [2:0] {
		EV_NONE  = 3'd0,
		EV_TUNED = 3'd1,
		EV_SLOT  = 3'd2,
		EV_ON    = 3'd3,
		EV_OFF   = 3'd4
	} tcfp_event_t;

endpackage

### sv/tcfp_in_if.sv
// ----------------------------------------------------------------------------
// Frame parser input channel
// Valid/ready channel that carries one received serial byte per item.
// ----------------------------------------------------------------------------
interface tcfp_in_if;

	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);

endinterface

### sv/tcfp_out_if.sv
// ----------------------------------------------------------------------------
// Frame parser result channel
// Valid/ready channel that carries one parser result per item.
// ----------------------------------------------------------------------------
interface tcfp_out_if;

	logic       valid;
	logic       ready;
	logic [2:0] event_res;
	logic [3:0] slot_index;
	logic [7:0] written_value;
	logic       switch_state;
	logic [7:0] tuned_value;

	modport source (
		output valid, output event_res, output slot_index, output written_value,
		output switch_state, output tuned_value, input ready
	);
	modport sink (
		input valid, input event_res, input slot_index, input written_value,
		input switch_state, input tuned_value, output ready
	);

endinterface

### sv/tcfp_float_dec.sv
// ----------------------------------------------------------------------------
// Single precision value decoder
// Truncates an IEEE single to an integer and gives both the value saturated
// to 0..255 and its low eight bits (zero if negative or at least 2^31).
// ----------------------------------------------------------------------------
module tcfp_float_dec (
	input  logic [31:0] word,
	output logic [7:0]  sat_val,
	output logic [7:0]  low_val
);
	import tcfp_pkg::*;

	logic [7:0]  expo;
	logic [7:0]  ex;
	logic [23:0] mant;
	logic [23:0] sat_shifted;
	logic [30:0] low_shifted;

	assign expo = word[30:23];
	assign ex   = expo - EXP_BIAS;
	assign mant = {1'b1, word[22:0]};

	assign sat_shifted = mant >> (SAT_SHIFT_BASE - {2'b00, ex[2:0]});
	assign low_shifted = {mant, 7'b0000000} >> (LOW_SHIFT_BASE - ex[4:0]);

	always_comb begin
		if (word[31]) begin
			sat_val = '0;
		end else if (expo == EXP_ALL_ONES) begin
			sat_val = (word[22:0] != '0) ? '0 : VALUE_MAX;
		end else if (expo < EXP_BIAS) begin
			sat_val = '0;
		end else if (ex >= SAT_EXP_LIMIT) begin
			sat_val = VALUE_MAX;
		end else begin
			sat_val = sat_shifted[7:0];
		end
	end

	always_comb begin
		if (word[31] || expo < EXP_BIAS || ex >= LOW_EXP_LIMIT) begin
			low_val = '0;
		end else begin
			low_val = low_shifted[7:0];
		end
	end

endmodule

### sv/tuning_command_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// Tuning command frame parser
// Path: an accepted byte goes to the input register, then a single decode stage
// updates the frame state once per byte, then the result register takes it.
// Throughput: one byte per cycle unless out_ch.ready stalls the output.
// Reset clears the frame state, tuned value, switch and both valid flags.
// ----------------------------------------------------------------------------
module tuning_command_frame_parser_unit (
	input  logic clk,
	input  logic arst_n,
	tcfp_in_if.sink    in_ch,
	tcfp_out_if.source out_ch
);
	import tcfp_pkg::*;

	typedef enum logic [2:0] {
		PH_WAIT,
		PH_MODE,
		PH_PARAM,
		PH_SELECT,
		PH_SWITCH
	} phase_t;

	logic        valid_s1;
	logic [7:0]  rx_byte_s1;
	logic        adv;

	phase_t      phase_q, phase_d;
	logic [2:0]  count_q, count_d;
	logic [7:0]  cmd_q [4];
	logic        wr_buf;
	logic [7:0]  tuned_q, tuned_d;
	logic        switch_q, switch_d;

	tcfp_event_t ev_d;
	logic [3:0]  slot_d;
	logic [7:0]  val_d;

	logic        valid_s2;
	tcfp_event_t event_s2;
	logic [3:0]  slot_s2;
	logic [7:0]  val_s2;
	logic        switch_s2;
	logic [7:0]  tuned_s2;

	logic [31:0] word;
	logic [7:0]  sat_val;
	logic [7:0]  low_val;
	logic        all_on;
	logic        all_off;

	assign adv         = !valid_s2 || out_ch.ready;
	assign in_ch.ready = !valid_s1 || adv;

	assign word = {cmd_q[1], cmd_q[2], cmd_q[3], rx_byte_s1};

	assign all_on = (cmd_q[0] == SWITCH_ON_BYTE) && (cmd_q[1] == SWITCH_ON_BYTE) &&
		(cmd_q[2] == SWITCH_ON_BYTE) && (cmd_q[3] == SWITCH_ON_BYTE) &&
		(rx_byte_s1 == SWITCH_ON_BYTE);
	assign all_off = (cmd_q[0] == SWITCH_OFF_BYTE) && (cmd_q[1] == SWITCH_OFF_BYTE) &&
		(cmd_q[2] == SWITCH_OFF_BYTE) && (cmd_q[3] == SWITCH_OFF_BYTE) &&
		(rx_byte_s1 == SWITCH_OFF_BYTE);

	tcfp_float_dec u_dec (
		.word    (word),
		.sat_val (sat_val),
		.low_val (low_val)
	);

	always_comb begin
		phase_d  = phase_q;
		count_d  = count_q;
		wr_buf   = 1'b0;
		tuned_d  = tuned_q;
		switch_d = switch_q;
		ev_d     = EV_NONE;
		slot_d   = '0;
		val_d    = '0;
		case (phase_q)
			PH_WAIT: begin
				if (rx_byte_s1 == HEADER_BYTE) begin
					phase_d = PH_MODE;
				end
			end
			PH_MODE: begin
				case (rx_byte_s1)
					MODE_PARAM: begin
						phase_d = PH_PARAM;
						count_d = '0;
					end
					MODE_SELECT: begin
						phase_d = PH_SELECT;
						count_d = '0;
					end
					MODE_SWITCH: begin
						phase_d = PH_SWITCH;
						count_d = '0;
					end
					default: begin
						phase_d = PH_MODE;
					end
				endcase
			end
			PH_PARAM, PH_SELECT, PH_SWITCH: begin
				if (count_q == FRAME_LAST) begin
					phase_d = PH_WAIT;
					count_d = '0;
					if (phase_q == PH_PARAM) begin
						if (cmd_q[0] == '0) begin
							tuned_d = sat_val;
							ev_d    = EV_TUNED;
							val_d   = sat_val;
						end
					end else if (phase_q == PH_SELECT) begin
						if (cmd_q[0] < SELECT_SLOTS) begin
							ev_d   = EV_SLOT;
							slot_d = cmd_q[0][3:0];
							val_d  = low_val;
						end
					end else begin
						if (all_on) begin
							switch_d = 1'b1;
							ev_d     = EV_ON;
							val_d    = VALUE_ONE;
						end else if (all_off) begin
							switch_d = 1'b0;
							ev_d     = EV_OFF;
						end
					end
				end else begin
					wr_buf  = 1'b1;
					count_d = count_q + 3'd1;
				end
			end
			default: begin
				phase_d = PH_WAIT;
				count_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			phase_q  <= PH_WAIT;
			count_q  <= '0;
			tuned_q  <= '0;
			switch_q <= 1'b0;
		end else begin
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
			if (adv && valid_s1) begin
				phase_q  <= phase_d;
				count_q  <= count_d;
				tuned_q  <= tuned_d;
				switch_q <= switch_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			rx_byte_s1 <= in_ch.rx_byte;
		end
		if (adv && valid_s1) begin
			if (wr_buf) begin
				cmd_q[count_q[1:0]] <= rx_byte_s1;
			end
			event_s2  <= ev_d;
			slot_s2   <= slot_d;
			val_s2    <= val_d;
			switch_s2 <= switch_d;
			tuned_s2  <= tuned_d;
		end
	end

	assign out_ch.valid         = valid_s2;
	assign out_ch.event_res     = event_s2;
	assign out_ch.slot_index    = slot_s2;
	assign out_ch.written_value = val_s2;
	assign out_ch.switch_state  = switch_s2;
	assign out_ch.tuned_value   = tuned_s2;

`ifndef ASSERT_OFF
	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(rx_byte_s1))
		else $error("input stage item changed while stalled");

	a_tuned_match: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && event_s2 == EV_TUNED |-> val_s2 == tuned_s2)
		else $error("tuned value result differs from tuned store");

	a_switch_match: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (event_s2 == EV_ON || event_s2 == EV_OFF) |->
		switch_s2 == (event_s2 == EV_ON))
		else $error("switch state differs from switch event");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (event_s2 == EV_SLOT) ? ({4'b0000, slot_s2} < SELECT_SLOTS)
		: (slot_s2 == '0))
		else $error("slot index out of range or set without a slot write");
`endif

endmodule
